// ----- rtl/core/lzss_pkg.sv -----
`timescale 1ns / 1ps

package lzss_pkg;

  localparam int unsigned ADDR_W   = 12;
  localparam int unsigned DEPTH    = 4096;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned EPOCH_W  = 8;
  localparam int unsigned MEM_W    = BYTE_W + EPOCH_W;
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned TOK_W    = 9;
  localparam int unsigned CFG_W    = 12;
  localparam int unsigned IDX_W    = 1;

  localparam logic [ADDR_W-1:0]  WINDOW_START_RST = 12'hfee;
  localparam logic [BYTE_W-1:0]  FILL_BYTE_RST    = 8'h00;
  localparam logic [LEN_W-1:0]   LEN_BIAS         = 5'd3;
  localparam logic [TOK_W-1:0]   TOK_MARKER       = 9'h100;
  localparam logic [EPOCH_W-1:0] EPOCH_CLEARED    = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST      = 8'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST       = '1;

  localparam logic [IDX_W-1:0] REG_WINDOW_START = 1'b0;
  localparam logic [IDX_W-1:0] REG_FILL_BYTE    = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COPY
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] window_start;
    logic [BYTE_W-1:0] fill_byte;
    logic              ws_load;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [MEM_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ----- rtl/core/lzss_window_decompressor.sv -----
`timescale 1ns / 1ps
// flag and offset bytes go in whenever idle; a literal appears in the cycle after it is taken
// a match request of n bytes (3 to 18) holds the input until the copy ends, one byte a cycle
// if output is free, set by the ram's single read port; its first byte passes the ram read
// and output registers; reset starts a clearing pass over all 4096 entries, input stalled
// meanwhile; it runs again after every 255th end of stream, when the 8-bit stream tag wraps
module lzss_window_decompressor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [lzss_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [lzss_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 compressed_byte_i,
  input  logic                       last_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 out_byte_o,
  output logic                       run_last_o
);

  logic [lzss_pkg::ADDR_W-1:0] ws_q, ws_d;
  logic [lzss_pkg::BYTE_W-1:0] fill_q, fill_d;
  logic                        cfg_we;
  lzss_pkg::cfg_t              cfg;
  lzss_pkg::mem_req_t          mem_req;
  logic [lzss_pkg::MEM_W-1:0]  mem_rdata;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    ws_d   = ws_q;
    fill_d = fill_q;
    if (cfg_we) begin
      case (cfg_index_i)
        lzss_pkg::REG_WINDOW_START: ws_d = cfg_data_i[lzss_pkg::ADDR_W-1:0];
        lzss_pkg::REG_FILL_BYTE:    fill_d = cfg_data_i[lzss_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q   <= lzss_pkg::WINDOW_START_RST;
      fill_q <= lzss_pkg::FILL_BYTE_RST;
    end else begin
      ws_q   <= ws_d;
      fill_q <= fill_d;
    end
  end

  // a window_start write also moves the write position
  assign cfg.window_start = ws_d;
  assign cfg.fill_byte    = fill_q;
  assign cfg.ws_load      = cfg_we && (cfg_index_i == lzss_pkg::REG_WINDOW_START);

  lzss_ram #(
    .WIDTH(lzss_pkg::MEM_W),
    .DEPTH(lzss_pkg::DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_req.we),
    .waddr_i(mem_req.waddr),
    .wdata_i(mem_req.wdata),
    .re_i   (mem_req.re),
    .raddr_i(mem_req.raddr),
    .rdata_o(mem_rdata)
  );

  lzss_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .compressed_byte_i(compressed_byte_i),
    .last_byte_i      (last_byte_i),
    .in_stall_o       (in_stall_o),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .run_last_o       (run_last_o),
    .mem_req_o        (mem_req),
    .mem_rdata_i      (mem_rdata)
  );

endmodule

// ----- rtl/core/lzss_ram.sv -----
`timescale 1ns / 1ps

module lzss_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/lzss_core.sv -----
`timescale 1ns / 1ps

module lzss_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lzss_pkg::cfg_t             cfg_i,
  input  logic                       in_valid_i,
  input  logic [7:0]                 compressed_byte_i,
  input  logic                       last_byte_i,
  output logic                       in_stall_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 out_byte_o,
  output logic                       run_last_o,
  output lzss_pkg::mem_req_t         mem_req_o,
  input  logic [lzss_pkg::MEM_W-1:0] mem_rdata_i
);

  lzss_pkg::state_e state_q, state_d;

  logic [lzss_pkg::TOK_W-1:0]   tok_q, tok_d;
  logic                         second_q, second_d;
  logic [7:0]                   offl_q, offl_d;
  logic [lzss_pkg::ADDR_W-1:0]  wp_q, wp_d;
  logic [lzss_pkg::EPOCH_W-1:0] epoch_q, epoch_d;
  logic [lzss_pkg::ADDR_W-1:0]  clr_q, clr_d;
  logic [lzss_pkg::ADDR_W-1:0]  src_q, src_d;
  logic [lzss_pkg::LEN_W-1:0]   rd_left_q, rd_left_d;
  logic [lzss_pkg::LEN_W-1:0]   cnt_q, cnt_d;
  logic                         pend_q, pend_d;
  logic                         fwd_q, fwd_d;
  logic [7:0]                   fwd_data_q, fwd_data_d;
  logic                         last_pend_q, last_pend_d;
  logic                         out_valid_q, out_valid_d;
  logic [7:0]                   out_byte_q, out_byte_d;
  logic                         out_last_q, out_last_d;

  logic       out_free, is_lit, is_flag, in_acc;
  logic       consume, issue, copy_done, restart, clr_done;
  logic [7:0] rd_val, cval;

  assign out_free = !out_valid_q || !out_stall_i;
  assign is_flag  = !second_q && (tok_q[lzss_pkg::TOK_W-1:1] == '0);
  assign is_lit   = !second_q && !is_flag && tok_q[0];

  assign in_stall_o = (state_q != lzss_pkg::ST_IDLE) || (is_lit && !out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign consume   = (state_q == lzss_pkg::ST_COPY) && pend_q && out_free;
  assign issue     = (state_q == lzss_pkg::ST_COPY) && (rd_left_q != '0) && (!pend_q || consume);
  assign copy_done = consume && (cnt_q == lzss_pkg::LEN_W'(1));
  assign restart   = (in_acc && last_byte_i && !second_q) || (copy_done && last_pend_q);
  assign clr_done  = (state_q == lzss_pkg::ST_CLEAR) && (clr_q == '1);

  // entries written in an older stream read as the fill byte
  assign rd_val = (mem_rdata_i[lzss_pkg::MEM_W-1:lzss_pkg::BYTE_W] == epoch_q) ?
                  mem_rdata_i[lzss_pkg::BYTE_W-1:0] : cfg_i.fill_byte;
  assign cval   = fwd_q ? fwd_data_q : rd_val;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lzss_pkg::ST_CLEAR: begin
        if (clr_done) state_d = lzss_pkg::ST_IDLE;
      end
      lzss_pkg::ST_IDLE: begin
        if (in_acc && second_q) state_d = lzss_pkg::ST_COPY;
        else if (restart && epoch_q == lzss_pkg::EPOCH_LAST) state_d = lzss_pkg::ST_CLEAR;
      end
      lzss_pkg::ST_COPY: begin
        if (copy_done) begin
          if (restart && epoch_q == lzss_pkg::EPOCH_LAST) state_d = lzss_pkg::ST_CLEAR;
          else state_d = lzss_pkg::ST_IDLE;
        end
      end
      default: state_d = lzss_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    tok_d       = tok_q;
    second_d    = second_q;
    offl_d      = offl_q;
    wp_d        = wp_q;
    epoch_d     = epoch_q;
    clr_d       = clr_q;
    src_d       = src_q;
    rd_left_d   = rd_left_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    fwd_d       = fwd_q;
    fwd_data_d  = fwd_data_q;
    last_pend_d = last_pend_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    mem_req_o   = '0;

    case (state_q)
      lzss_pkg::ST_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = clr_q;
        mem_req_o.wdata = {lzss_pkg::EPOCH_CLEARED, 8'h00};
        clr_d           = clr_q + 1'b1;
        if (clr_done) epoch_d = lzss_pkg::EPOCH_FIRST;
      end
      lzss_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (second_q) begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = {compressed_byte_i[7:4], offl_q};
            src_d           = {compressed_byte_i[7:4], offl_q} + 1'b1;
            cnt_d           = {1'b0, compressed_byte_i[3:0]} + lzss_pkg::LEN_BIAS;
            rd_left_d       = {1'b0, compressed_byte_i[3:0]} + lzss_pkg::LEN_BIAS - 1'b1;
            pend_d          = 1'b1;
            fwd_d           = 1'b0;
            last_pend_d     = last_byte_i;
            tok_d           = tok_q >> 1;
            second_d        = 1'b0;
          end else if (is_flag) begin
            tok_d = {1'b0, compressed_byte_i} | lzss_pkg::TOK_MARKER;
          end else if (is_lit) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = wp_q;
            mem_req_o.wdata = {epoch_q, compressed_byte_i};
            wp_d            = wp_q + 1'b1;
            out_valid_d     = 1'b1;
            out_byte_d      = compressed_byte_i;
            out_last_d      = 1'b1;
            tok_d           = tok_q >> 1;
          end else begin
            offl_d   = compressed_byte_i;
            second_d = 1'b1;
          end
        end
      end
      lzss_pkg::ST_COPY: begin
        if (consume) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = wp_q;
          mem_req_o.wdata = {epoch_q, cval};
          wp_d            = wp_q + 1'b1;
          cnt_d           = cnt_q - 1'b1;
          out_valid_d     = 1'b1;
          out_byte_d      = cval;
          out_last_d      = copy_done;
          pend_d          = 1'b0;
          fwd_d           = 1'b0;
        end
        if (issue) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = src_q;
          src_d           = src_q + 1'b1;
          rd_left_d       = rd_left_q - 1'b1;
          pend_d          = 1'b1;
          // the ram returns old data when the same entry is written this cycle
          fwd_d           = consume && (src_q == wp_q);
          fwd_data_d      = cval;
        end
      end
      default: ;
    endcase

    if (restart) begin
      tok_d    = '0;
      second_d = 1'b0;
      offl_d   = '0;
      wp_d     = cfg_i.window_start;
      epoch_d  = epoch_q + 1'b1;
      clr_d    = '0;
    end
    if (cfg_i.ws_load) begin
      wp_d = cfg_i.window_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lzss_pkg::ST_CLEAR;
      tok_q       <= '0;
      second_q    <= 1'b0;
      wp_q        <= lzss_pkg::WINDOW_START_RST;
      epoch_q     <= lzss_pkg::EPOCH_CLEARED;
      clr_q       <= '0;
      rd_left_q   <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      fwd_q       <= 1'b0;
      last_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      tok_q       <= tok_d;
      second_q    <= second_d;
      wp_q        <= wp_d;
      epoch_q     <= epoch_d;
      clr_q       <= clr_d;
      rd_left_q   <= rd_left_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      fwd_q       <= fwd_d;
      last_pend_q <= last_pend_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    offl_q     <= offl_d;
    src_q      <= src_d;
    fwd_data_q <= fwd_data_d;
    out_byte_q <= out_byte_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = out_last_q;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

import lzss_pkg::*;

typedef struct packed {
  logic [BYTE_W-1:0] data;
  logic              run_end;
} out_byte_t;

class lzss_scoreboard;
  logic [ADDR_W-1:0] start_pos;
  logic [ADDR_W-1:0] write_pos;
  logic [BYTE_W-1:0] fill;
  logic [TOK_W-1:0]  tokens;
  bit                match_half;
  logic [7:0]        offset_lo;
  logic [7:0]        history [DEPTH];
  bit                written [DEPTH];
  out_byte_t         expected_q [$];
  int                errors;

  function new();
    start_pos = WINDOW_START_RST;
    fill = FILL_BYTE_RST;
    errors = 0;
    restart();
  endfunction

  function void restart();
    tokens = '0;
    match_half = 1'b0;
    offset_lo = '0;
    write_pos = start_pos;
    foreach (written[i]) written[i] = 1'b0;
  endfunction

  function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    if (idx == REG_WINDOW_START) begin
      start_pos = d[ADDR_W-1:0];
      write_pos = start_pos;
    end else if (idx == REG_FILL_BYTE) begin
      fill = d[BYTE_W-1:0];
    end
  endfunction

  function void put_byte(logic [7:0] v);
    history[write_pos] = v;
    written[write_pos] = 1'b1;
    write_pos++;
    expected_q.push_back('{data: v, run_end: 1'b0});
  endfunction

  // decode one accepted compressed byte into the bytes it releases
  function void take_compressed(logic [7:0] b, logic fin);
    int produced;
    int len;
    logic [ADDR_W-1:0] src;
    produced = 0;
    if (match_half) begin
      src = {b[7:4], offset_lo};
      len = b[3:0] + 3;
      for (int i = 0; i < len; i++) begin
        put_byte(written[src] ? history[src] : fill);
        src++;
      end
      produced = len;
      tokens = tokens >> 1;
      match_half = 1'b0;
    end else if (tokens <= 1) begin
      tokens = {1'b1, b};
    end else if (tokens[0]) begin
      put_byte(b);
      produced = 1;
      tokens = tokens >> 1;
    end else begin
      offset_lo = b;
      match_half = 1'b1;
    end
    if (produced > 0) expected_q[expected_q.size()-1].run_end = 1'b1;
    if (fin) restart();
  endfunction

  function void check_output(logic [7:0] b, logic l);
    out_byte_t want;
    if (expected_q.size() == 0) begin
      $error("out_byte: nothing expected, got %h", b);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (b !== want.data) begin
      $error("out_byte: expected %h, got %h", want.data, b);
      errors++;
    end
    if (l !== want.run_end) begin
      $error("run_last: expected %b, got %b", want.run_end, l);
      errors++;
    end
  endfunction
endclass

module tb_top;

  localparam int DRAIN_CYCLES = 4;
  localparam int END_CYCLES   = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 45;
  localparam int CYCLE_LIMIT  = 200000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_W-1:0]  cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [7:0]        compressed_byte_i = '0;
  logic              last_byte_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [7:0]        out_byte_o;
  logic              run_last_o;

  lzss_scoreboard sb = new();
  int tx_idle_pct = 25;
  int rx_idle_pct = 25;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int sent_items = 0;
  int cycle_count = 0;

  lzss_window_decompressor uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_output(out_byte_o, run_last_o);
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    compressed_byte_i <= b;
    last_byte_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_compressed(b, fin);
    sent_items++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [ADDR_W-1:0] ws, input logic [BYTE_W-1:0] fb);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_WINDOW_START;
    cfg_data_i <= CFG_W'(ws);
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(REG_WINDOW_START, CFG_W'(ws));
    cfg_index_i <= REG_FILL_BYTE;
    cfg_data_i <= CFG_W'(fb);
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(REG_FILL_BYTE, CFG_W'(fb));
    cfg_valid_i <= 1'b0;
  endtask

  // back reference aimed at recent history, a short run, or anywhere
  task automatic send_match(input logic fin, input logic cut);
    logic [ADDR_W-1:0] src;
    logic [3:0] len;
    case ($urandom_range(0, 3))
      0:       src = sb.write_pos - 1'b1;
      1:       src = sb.write_pos - ADDR_W'($urandom_range(1, 40));
      2:       src = ADDR_W'($urandom);
      default: src = sb.write_pos - ADDR_W'($urandom_range(2, 20));
    endcase
    len = ($urandom_range(0, 4) == 0) ? 4'hf : 4'($urandom);
    send_byte(src[7:0], fin && cut);
    if (!(fin && cut)) send_byte({src[11:8], len}, fin);
  endtask

  task automatic send_stream();
    int groups;
    int n_tail;
    int ending;
    int n_tok;
    logic [7:0] flags;
    logic fin;
    groups = $urandom_range(1, 3);
    n_tail = $urandom_range(1, 8);
    ending = $urandom_range(0, 9);
    for (int g = 0; g < groups; g++) begin
      flags = 8'($urandom);
      if (g == groups - 1 && ending == 7) begin
        send_byte(flags, 1'b1);
        return;
      end
      send_byte(flags, 1'b0);
      n_tok = (g == groups - 1) ? n_tail : 8;
      for (int k = 0; k < n_tok; k++) begin
        fin = (g == groups - 1) && (k == n_tok - 1) && (ending != 9);
        if (flags[k]) send_byte(8'($urandom), fin);
        else send_match(fin, ending == 8);
      end
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 15) == 0);
  endtask

  task automatic run_phase(input int n_items, input bit pause_mid);
    int target;
    target = sent_items + n_items;
    while (sent_items < target) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_stream();
      if (pause_mid && sent_items >= target - n_items / 2) begin
        drain();
        pause_mid = 1'b0;
      end
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // default settings: literal, overlapping copy, wrapping copy over unwritten entries,
    // stream cut off after a match head
    send_byte(8'h05, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hee, 1'b0);
    send_byte(8'hf0, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h0f, 1'b0);
    send_byte(8'h10, 1'b1);
    drain();

    write_regs(12'h000, 8'hff);
    send_byte(8'hfc, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hf0, 1'b0);
    drain();
    // window start moved mid-stream
    write_regs(12'h800, 8'h5a);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7f, 1'b1);
    // stream made of a lone flag byte
    send_byte(8'h3c, 1'b1);
    drain();

    write_regs(12'hfff, 8'h00);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hfe, 1'b0);
    send_byte(8'h7f, 1'b1);
    drain();

    write_regs(WINDOW_START_RST, FILL_BYTE_RST);
    run_phase(PHASE_ITEMS, 1'b0);

    // receiver holds off while the sender keeps pushing
    write_regs(12'h000, 8'hff);
    tx_idle_pct = 0;
    hold_request = 1'b1;
    run_phase(PHASE_ITEMS, 1'b0);

    // no idling on either side, with a full pause halfway
    write_regs(12'hfff, 8'h80);
    rx_idle_pct = 0;
    run_phase(PHASE_ITEMS, 1'b1);

    tx_idle_pct = 25;
    rx_idle_pct = 25;
    write_regs(ADDR_W'($urandom), BYTE_W'($urandom));
    run_phase(PHASE_ITEMS, 1'b0);

    repeat (END_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/lzss_pkg.sv
rtl/core/lzss_ram.sv
rtl/core/lzss_core.sv
rtl/core/lzss_window_decompressor.sv
tb/tb_top.sv
